// ===== hw/rtl/ttn_pkg.sv =====
package ttn_pkg;

    localparam int RATE_BITS = 40;
    localparam int IVL_BITS  = 40;
    localparam logic [IVL_BITS-1:0]  GUARD_NS       = 40'd1000;
    localparam logic [IVL_BITS-1:0]  INTERVAL_RESET = 40'd3000000000;
    localparam logic [RATE_BITS-1:0] RATE_MAX       = {RATE_BITS{1'b1}};

    typedef enum logic [1:0] {
        FUNC_CONVERT = 2'd0,
        FUNC_INIT    = 2'd1,
        FUNC_CAL     = 2'd2,
        FUNC_SPARE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        STAT_CONVERTED  = 3'd0,
        STAT_SAMPLE     = 3'd1,
        STAT_BASE       = 3'd2,
        STAT_RATE_SET   = 3'd3,
        STAT_CALIBRATED = 3'd4,
        STAT_SKIPPED    = 3'd5,
        STAT_NO_INIT    = 3'd6,
        STAT_ZERO_DIV   = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] tick;
        logic [63:0] ref_ns;
        logic        first;
    } t_in_word;

    typedef struct packed {
        logic [63:0] ns_value;
        logic        calibration_due;
        logic [2:0]  status;
    } t_out_word;

    function automatic logic [RATE_BITS-1:0] clamp_rate(input logic [63:0] r);
        logic [RATE_BITS-1:0] res;
        if (r > {{(64-RATE_BITS){1'b0}}, RATE_MAX}) begin
            res = RATE_MAX;
        end else if (r == 64'd0) begin
            res = {{(RATE_BITS-1){1'b0}}, 1'b1};
        end else begin
            res = r[RATE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/ttn_if.sv =====
interface ttn_in_if;
    import ttn_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ttn_out_if;
    import ttn_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tick_to_ns_calibrator_unit.sv =====
// channel   dir  payload                                handshake
// i_in      in   func, tick, ref_ns, first              valid/ready
// o_out     out  ns_value, calibration_due, status      valid/ready
// apb       in   calibrate_interval at byte address 0   psel/penable, pready tied high
//
// one word at a time through a shared shift-add multiplier and restoring divider
// convert runs one 64-step multiply
// init set completion runs up to two 128-step divides
// calibration completion runs up to three multiplies and up to three divides
// synchronous active-low reset; i_in.ready is low until the result word is taken
module tick_to_ns_calibrator_unit
    import ttn_pkg::*;
#(
    parameter int SAMPLE_PAIRS   = 3,
    parameter int RATE_FRAC_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttn_in_if.sink      i_in,
    ttn_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(SAMPLE_PAIRS + 1);
    localparam logic [CNT_W-1:0] PAIRS = CNT_W'(SAMPLE_PAIRS);

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_DECODE   = 17'h00002,
        S_FIN      = 17'h00004,
        S_MUL      = 17'h00008,
        S_DIV      = 17'h00010,
        S_CONV     = 17'h00020,
        S_INIT_Q   = 17'h00040,
        S_SAVE     = 17'h00080,
        S_SAVE_Q   = 17'h00100,
        S_CAL_CALC = 17'h00200,
        S_CAL_ERR  = 17'h00400,
        S_CAL_OINT = 17'h00800,
        S_CAL_SDIV = 17'h01000,
        S_CAL_MAG  = 17'h02000,
        S_CAL_CORR = 17'h04000,
        S_CAL_RATE = 17'h08000,
        S_OUT      = 17'h10000
    } t_state;

    // control and architectural state
    t_state               r_state, n_state, r_ret, n_ret;
    logic [IVL_BITS-1:0]  r_interval, n_interval;
    logic [63:0]          r_base_tick, n_base_tick, r_base_nanos, n_base_nanos;
    logic [RATE_BITS-1:0] r_rate, n_rate;
    logic [63:0]          r_base_err, n_base_err, r_next_cal, n_next_cal;
    logic                 r_rate_valid, n_rate_valid, r_pending, n_pending;
    logic [63:0]          r_pend_tick, n_pend_tick, r_pend_nanos, n_pend_nanos;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_skip, n_skip;
    logic [6:0]           r_cnt, n_cnt;

    // payload
    logic [63:0]          r_prev, n_prev, r_best_gap, n_best_gap;
    logic [63:0]          r_best_mid, n_best_mid, r_best_ref, n_best_ref;
    logic [1:0]           r_func, n_func;
    logic [63:0]          r_tick, n_tick, r_ref, n_ref;
    logic                 r_first, n_first;
    logic [127:0]         r_acc, n_acc;
    logic [63:0]          r_opa, n_opa, r_opb, n_opb, r_rem, n_rem;
    logic [63:0]          r_calc, n_calc, r_err, n_err, r_spent, n_spent, r_exp, n_exp;
    logic                 r_sgn, n_sgn;
    logic [63:0]          r_sv_t, n_sv_t, r_sv_ns, n_sv_ns, r_sv_err, n_sv_err;
    logic [RATE_BITS-1:0] r_rate_new, n_rate_new;
    logic [63:0]          r_ns_out, n_ns_out;
    logic                 r_due, n_due;
    t_status              r_status, n_status;

    logic [64:0]          mul_sum;
    logic [63:0]          div_sh, div_diff;
    logic                 div_ge;
    logic [63:0]          prod_slice, smp_gap, smp_mid, q_sat, mag, ma, mb, sq;
    logic                 due_now;
    logic [RATE_BITS:0]   ql;
    logic [RATE_BITS+1:0] rate_sum;
    logic [63:0]          rate_pre;
    logic                 cfg_wr;

    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite & ~paddr[3];
    assign prdata      = paddr[3] ? 64'd0 : {{(64-IVL_BITS){1'b0}}, r_interval};
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data  = '{ns_value: r_ns_out, calibration_due: r_due, status: r_status};

    assign mul_sum    = {1'b0, r_acc[127:64]} + (r_opb[0] ? {1'b0, r_opa} : 65'd0);
    assign div_sh     = {r_rem[62:0], r_acc[127]};
    assign div_ge     = r_rem[63] | (div_sh >= r_opa);
    assign div_diff   = div_sh - r_opa;
    assign prod_slice = r_acc[RATE_FRAC_BITS +: 64];
    assign q_sat      = (r_acc[127:64] != 64'd0) ? {64{1'b1}} : r_acc[63:0];
    assign due_now    = (r_tick >= r_next_cal);
    assign smp_gap    = r_tick - r_prev;
    assign smp_mid    = {1'b0, r_prev[63:1]} + {1'b0, r_tick[63:1]}
                        + {63'd0, r_prev[0] & r_tick[0]};
    assign mag        = r_exp[63] ? (64'd0 - r_exp) : r_exp;
    assign ma         = r_acc[63] ? (64'd0 - r_acc[63:0]) : r_acc[63:0];
    assign mb         = r_spent[63] ? (64'd0 - r_spent) : r_spent;
    assign sq         = r_sgn ? (r_err - r_acc[63:0]) : (r_err + r_acc[63:0]);
    assign ql         = ((r_acc[127:64] != 64'd0)
                        || (r_acc[63:0] > {{(64-RATE_BITS){1'b0}}, RATE_MAX}))
                        ? {1'b1, {RATE_BITS{1'b0}}} : r_acc[RATE_BITS:0];
    assign rate_sum   = {2'b0, r_rate} + {1'b0, ql};

    always_comb begin
        if (!r_exp[63]) begin
            rate_pre = (ql >= {1'b0, r_rate}) ? 64'd1
                       : {{(64-RATE_BITS){1'b0}}, r_rate - ql[RATE_BITS-1:0]};
        end else begin
            rate_pre = {{(64-RATE_BITS-2){1'b0}}, rate_sum};
        end
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_interval = r_interval;
        n_base_tick = r_base_tick;  n_base_nanos = r_base_nanos;  n_rate = r_rate;
        n_base_err = r_base_err;  n_next_cal = r_next_cal;
        n_rate_valid = r_rate_valid;  n_pending = r_pending;
        n_pend_tick = r_pend_tick;  n_pend_nanos = r_pend_nanos;
        n_count = r_count;  n_skip = r_skip;  n_cnt = r_cnt;
        n_prev = r_prev;  n_best_gap = r_best_gap;  n_best_mid = r_best_mid;
        n_best_ref = r_best_ref;  n_func = r_func;  n_tick = r_tick;  n_ref = r_ref;
        n_first = r_first;  n_acc = r_acc;  n_opa = r_opa;  n_opb = r_opb;
        n_rem = r_rem;  n_calc = r_calc;  n_err = r_err;  n_spent = r_spent;
        n_exp = r_exp;  n_sgn = r_sgn;  n_sv_t = r_sv_t;  n_sv_ns = r_sv_ns;
        n_sv_err = r_sv_err;  n_rate_new = r_rate_new;  n_ns_out = r_ns_out;
        n_due = r_due;  n_status = r_status;

        if (cfg_wr) begin
            n_interval = pwdata[IVL_BITS-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func  = i_in.data.func;
                    n_tick  = i_in.data.tick;
                    n_ref   = i_in.data.ref_ns;
                    n_first = i_in.data.first;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_due    = due_now;
                n_ns_out = 64'd0;
                n_state  = S_OUT;
                if (r_func == FUNC_INIT || r_func == FUNC_CAL) begin
                    if (r_first) begin
                        n_prev   = r_tick;
                        n_count  = '0;
                        n_skip   = (r_func == FUNC_CAL) && !due_now;
                        n_status = n_skip ? STAT_SKIPPED : STAT_SAMPLE;
                    end else if (r_count >= PAIRS) begin
                        n_status = STAT_SKIPPED;
                    end else begin
                        if (r_count == '0 || smp_gap < r_best_gap) begin
                            n_best_gap = smp_gap;
                            n_best_mid = smp_mid;
                            n_best_ref = r_ref;
                        end
                        n_prev   = r_tick;
                        n_count  = r_count + 1'b1;
                        n_status = r_skip ? STAT_SKIPPED : STAT_SAMPLE;
                        if (n_count >= PAIRS && !r_skip) begin
                            n_state = S_FIN;
                        end
                    end
                end else if (!r_rate_valid) begin
                    n_status = STAT_NO_INIT;
                end else begin
                    n_opa   = r_tick - r_base_tick;
                    n_opb   = {{(64-RATE_BITS){1'b0}}, r_rate};
                    n_acc   = '0;
                    n_cnt   = 7'd63;
                    n_ret   = S_CONV;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = {mul_sum, r_acc[63:1]};
                n_opb = {1'b0, r_opb[63:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 7'd0) begin
                    n_state = r_ret;
                end
            end
            S_DIV: begin
                n_rem = div_ge ? div_diff : div_sh;
                n_acc = {r_acc[126:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 7'd0) begin
                    n_state = r_ret;
                end
            end
            S_CONV: begin
                n_ns_out = r_base_nanos + prod_slice;
                n_status = STAT_CONVERTED;
                n_state  = S_OUT;
            end
            S_FIN: begin
                n_state = S_OUT;
                if (r_func == FUNC_INIT) begin
                    if (!r_pending) begin
                        n_pend_tick  = r_best_mid;
                        n_pend_nanos = r_best_ref;
                        n_pending    = 1'b1;
                        n_status     = STAT_BASE;
                    end else if (r_best_mid == r_pend_tick) begin
                        n_status = STAT_ZERO_DIV;
                    end else begin
                        n_acc   = {64'd0, r_best_ref - r_pend_nanos} << RATE_FRAC_BITS;
                        n_opa   = r_best_mid - r_pend_tick;
                        n_rem   = '0;
                        n_cnt   = 7'd127;
                        n_ret   = S_INIT_Q;
                        n_state = S_DIV;
                    end
                end else if (!r_rate_valid) begin
                    n_status = STAT_NO_INIT;
                end else begin
                    n_opa   = r_best_mid - r_base_tick;
                    n_opb   = {{(64-RATE_BITS){1'b0}}, r_rate};
                    n_acc   = '0;
                    n_cnt   = 7'd63;
                    n_ret   = S_CAL_CALC;
                    n_state = S_MUL;
                end
            end
            S_INIT_Q: begin
                n_rate_new = clamp_rate(q_sat);
                n_sv_t     = r_pend_tick;
                n_sv_ns    = r_pend_nanos;
                n_sv_err   = 64'd0;
                n_ns_out   = r_pend_nanos;
                n_status   = STAT_RATE_SET;
                n_state    = S_SAVE;
            end
            S_SAVE: begin
                if (r_interval > GUARD_NS) begin
                    n_acc   = {{(128-IVL_BITS){1'b0}}, r_interval - GUARD_NS}
                              << RATE_FRAC_BITS;
                    n_opa   = {{(64-RATE_BITS){1'b0}}, r_rate_new};
                    n_rem   = '0;
                    n_cnt   = 7'd127;
                    n_ret   = S_SAVE_Q;
                    n_state = S_DIV;
                end else begin
                    n_acc   = '0;
                    n_state = S_SAVE_Q;
                end
            end
            S_SAVE_Q: begin
                n_base_err   = r_sv_err;
                n_next_cal   = r_sv_t + q_sat;
                n_base_tick  = r_sv_t;
                n_base_nanos = r_sv_ns;
                n_rate       = r_rate_new;
                n_rate_valid = 1'b1;
                if (r_status == STAT_RATE_SET) begin
                    n_pending = 1'b0;
                end
                n_state = S_OUT;
            end
            S_CAL_CALC: begin
                n_calc  = r_base_nanos + prod_slice;
                n_state = S_CAL_ERR;
            end
            S_CAL_ERR: begin
                n_err   = r_calc - r_best_ref;
                n_spent = r_best_ref - r_base_nanos + r_base_err;
                if (n_spent == 64'd0 || r_interval == '0) begin
                    n_status = STAT_ZERO_DIV;
                    n_state  = S_OUT;
                end else begin
                    n_opa   = n_err - r_base_err;
                    n_opb   = {{(64-IVL_BITS){1'b0}}, r_interval};
                    n_acc   = '0;
                    n_cnt   = 7'd63;
                    n_ret   = S_CAL_OINT;
                    n_state = S_MUL;
                end
            end
            S_CAL_OINT: begin
                n_sgn   = r_acc[63] ^ r_spent[63];
                n_acc   = {64'd0, ma};
                n_opa   = mb;
                n_rem   = '0;
                n_cnt   = 7'd127;
                n_ret   = S_CAL_SDIV;
                n_state = S_DIV;
            end
            S_CAL_SDIV: begin
                n_exp   = sq;
                n_state = S_CAL_MAG;
            end
            S_CAL_MAG: begin
                n_opa   = mag;
                n_opb   = {{(64-RATE_BITS){1'b0}}, r_rate};
                n_acc   = '0;
                n_cnt   = 7'd63;
                n_ret   = S_CAL_CORR;
                n_state = S_MUL;
            end
            S_CAL_CORR: begin
                n_opa   = {{(64-IVL_BITS){1'b0}}, r_interval};
                n_rem   = '0;
                n_cnt   = 7'd127;
                n_ret   = S_CAL_RATE;
                n_state = S_DIV;
            end
            S_CAL_RATE: begin
                n_rate_new = clamp_rate(rate_pre);
                n_sv_t     = r_best_mid;
                n_sv_ns    = r_calc;
                n_sv_err   = r_err;
                n_ns_out   = r_calc;
                n_status   = STAT_CALIBRATED;
                n_state    = S_SAVE;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_interval   <= INTERVAL_RESET;
            r_base_tick  <= '0;
            r_base_nanos <= '0;
            r_rate       <= '0;
            r_base_err   <= '0;
            r_next_cal   <= '0;
            r_rate_valid <= 1'b0;
            r_pending    <= 1'b0;
            r_pend_tick  <= '0;
            r_pend_nanos <= '0;
            r_count      <= '0;
            r_skip       <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_interval   <= n_interval;
            r_base_tick  <= n_base_tick;
            r_base_nanos <= n_base_nanos;
            r_rate       <= n_rate;
            r_base_err   <= n_base_err;
            r_next_cal   <= n_next_cal;
            r_rate_valid <= n_rate_valid;
            r_pending    <= n_pending;
            r_pend_tick  <= n_pend_tick;
            r_pend_nanos <= n_pend_nanos;
            r_count      <= n_count;
            r_skip       <= n_skip;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_best_gap <= n_best_gap;
        r_best_mid <= n_best_mid;
        r_best_ref <= n_best_ref;
        r_func     <= n_func;
        r_tick     <= n_tick;
        r_ref      <= n_ref;
        r_first    <= n_first;
        r_acc      <= n_acc;
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_rem      <= n_rem;
        r_calc     <= n_calc;
        r_err      <= n_err;
        r_spent    <= n_spent;
        r_exp      <= n_exp;
        r_sgn      <= n_sgn;
        r_sv_t     <= n_sv_t;
        r_sv_ns    <= n_sv_ns;
        r_sv_err   <= n_sv_err;
        r_rate_new <= n_rate_new;
        r_ns_out   <= n_ns_out;
        r_due      <= n_due;
        r_status   <= n_status;
    end

endmodule
